// ----- src/hcbp_pkg.sv -----
package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 16;
    localparam int BYTE_W       = 8;
    localparam int SYM_W        = 8;
    localparam int LEN_W        = 5;
    localparam int PAD_W        = 3;
    localparam int PEND_W       = BYTE_W - 1;
    localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ACC_W        = PEND_W + MAX_CODE_LEN;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0]        len;
        logic [MAX_CODE_LEN-1:0] code;
    } table_entry_t;

    typedef struct packed {
        logic         flush;
        table_entry_t entry;
    } q_entry_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [PAD_W-1:0]  pad;
        logic              last;
    } result_t;

endpackage

// ----- src/hcbp_front.sv -----
module hcbp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [hcbp_pkg::SYM_W-1:0]      symbol,
    input  logic [hcbp_pkg::MAX_CODE_LEN-1:0] code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]      code_length,
    output logic                            push_valid,
    input  logic                            push_ready,
    output hcbp_pkg::q_entry_t              push_entry
);

    hcbp_pkg::table_entry_t code_table [hcbp_pkg::SYMBOL_COUNT];

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_flush_reg;
    hcbp_pkg::table_entry_t  rd_data_reg;

    logic                    accept;
    logic                    in_range;
    logic                    is_load;
    logic                    is_encode;
    logic                    is_flush;
    logic                    wr_en;
    logic                    rd_en;
    logic [hcbp_pkg::ADDR_W-1:0] addr;
    logic [hcbp_pkg::LEN_W-1:0]  sat_len;
    hcbp_pkg::table_entry_t  wr_entry;

    assign in_ready   = !s1_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign in_range   = ({1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT));
    assign addr       = hcbp_pkg::ADDR_W'(symbol);

    always_comb
    begin
        is_load   = 1'b0;
        is_encode = 1'b0;
        is_flush  = 1'b0;
        unique case (cmd)
            hcbp_pkg::CMD_LOAD:   is_load   = 1'b1;
            hcbp_pkg::CMD_ENCODE: is_encode = 1'b1;
            hcbp_pkg::CMD_FLUSH:  is_flush  = 1'b1;
            default: ;
        endcase
    end

    assign wr_en = accept && is_load && in_range;
    assign rd_en = accept && is_encode && in_range;

    always_comb
    begin
        if (code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN))
        begin
            sat_len = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN);
        end
        else
        begin
            sat_len = code_length;
        end
        wr_entry.len  = sat_len;
        wr_entry.code = hcbp_pkg::MAX_CODE_LEN'(
            {1'b0, code_bits} &
            (((hcbp_pkg::MAX_CODE_LEN + 1)'(1) << sat_len) - (hcbp_pkg::MAX_CODE_LEN + 1)'(1)));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_table[addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= code_table[addr];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (push_valid && push_ready)
        begin
            s1_valid_next = 1'b0;
        end
        if (rd_en || (accept && is_flush))
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flush_reg <= is_flush;
        end
    end

    assign push_valid       = s1_valid_reg;
    assign push_entry.flush = s1_flush_reg;
    assign push_entry.entry = rd_data_reg;

endmodule

// ----- src/hcbp_queue.sv -----
module hcbp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  hcbp_pkg::q_entry_t push_entry,
    output logic               pop_valid,
    input  logic               pop_ready,
    output hcbp_pkg::q_entry_t pop_entry
);

    hcbp_pkg::q_entry_t            slots [hcbp_pkg::QUEUE_DEPTH];
    logic [hcbp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [hcbp_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [hcbp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [hcbp_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [hcbp_pkg::QCNT_W-1:0]   count_reg;
    logic [hcbp_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == hcbp_pkg::QPTR_W'(hcbp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + hcbp_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == hcbp_pkg::QPTR_W'(hcbp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + hcbp_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + hcbp_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - hcbp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- src/hcbp_back.sv -----
module hcbp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  hcbp_pkg::q_entry_t           pop_entry,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]  out_byte,
    output logic [hcbp_pkg::PAD_W-1:0]   pad_bits,
    output logic                         last
);

    logic [hcbp_pkg::PEND_W-1:0] pend_reg;
    logic [hcbp_pkg::PEND_W-1:0] pend_next;
    logic [hcbp_pkg::PAD_W-1:0]  pcount_reg;
    logic [hcbp_pkg::PAD_W-1:0]  pcount_next;
    logic [1:0]                  rcnt_reg;
    logic [1:0]                  rcnt_next;
    hcbp_pkg::result_t           res0_reg;
    hcbp_pkg::result_t           res0_next;
    logic [hcbp_pkg::BYTE_W-1:0] res1_reg;
    logic [hcbp_pkg::BYTE_W-1:0] res1_next;

    logic                        out_fire;
    logic                        pop_fire;
    logic [hcbp_pkg::ACC_W-1:0]  acc;
    logic [hcbp_pkg::LEN_W-1:0]  total;
    logic [hcbp_pkg::LEN_W-1:0]  rem;
    logic [1:0]                  n;
    logic [hcbp_pkg::BYTE_W-1:0] byte0;
    logic [hcbp_pkg::BYTE_W-1:0] byte1;
    logic [hcbp_pkg::PAD_W-1:0]  pad;
    logic [hcbp_pkg::PEND_W-1:0] enc_pend;

    assign out_valid = (rcnt_reg != 2'd0);
    assign out_byte  = res0_reg.data;
    assign pad_bits  = res0_reg.pad;
    assign last      = res0_reg.last;
    assign out_fire  = out_valid && out_ready;
    assign pop_ready = (rcnt_reg == 2'd0) || ((rcnt_reg == 2'd1) && out_fire);
    assign pop_fire  = pop_valid && pop_ready;

    always_comb
    begin
        acc   = (hcbp_pkg::ACC_W'(pend_reg) << pop_entry.entry.len) |
                hcbp_pkg::ACC_W'(pop_entry.entry.code);
        total = hcbp_pkg::LEN_W'(pcount_reg) + pop_entry.entry.len;
        byte0 = hcbp_pkg::BYTE_W'(acc >> (total - hcbp_pkg::LEN_W'(8)));
        byte1 = hcbp_pkg::BYTE_W'(acc >> (total - hcbp_pkg::LEN_W'(16)));
        if (total >= hcbp_pkg::LEN_W'(16))
        begin
            n   = 2'd2;
            rem = total - hcbp_pkg::LEN_W'(16);
        end
        else if (total >= hcbp_pkg::LEN_W'(8))
        begin
            n   = 2'd1;
            rem = total - hcbp_pkg::LEN_W'(8);
        end
        else
        begin
            n   = 2'd0;
            rem = total;
        end
        enc_pend = hcbp_pkg::PEND_W'(acc & ((hcbp_pkg::ACC_W'(1) << rem) - hcbp_pkg::ACC_W'(1)));
        pad      = hcbp_pkg::PAD_W'(4'd8 - {1'b0, pcount_reg});
    end

    always_comb
    begin
        pend_next   = pend_reg;
        pcount_next = pcount_reg;
        res0_next   = res0_reg;
        res1_next   = res1_reg;
        rcnt_next   = rcnt_reg;
        if (out_fire)
        begin
            if (rcnt_reg == 2'd2)
            begin
                rcnt_next      = 2'd1;
                res0_next.data = res1_reg;
                res0_next.pad  = '0;
                res0_next.last = 1'b0;
            end
            else
            begin
                rcnt_next = 2'd0;
            end
        end
        if (pop_fire)
        begin
            if (pop_entry.flush)
            begin
                pend_next   = '0;
                pcount_next = '0;
                if (pcount_reg != '0)
                begin
                    rcnt_next      = 2'd1;
                    res0_next.data = hcbp_pkg::BYTE_W'({1'b0, pend_reg} << pad);
                    res0_next.pad  = pad;
                    res0_next.last = 1'b1;
                end
            end
            else
            begin
                pend_next      = enc_pend;
                pcount_next    = hcbp_pkg::PAD_W'(rem);
                rcnt_next      = n;
                res0_next.data = byte0;
                res0_next.pad  = '0;
                res0_next.last = 1'b0;
                res1_next      = byte1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            pcount_reg <= '0;
            rcnt_reg   <= 2'd0;
        end
        else
        begin
            pend_reg   <= pend_next;
            pcount_reg <= pcount_next;
            rcnt_reg   <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

endmodule

// ----- src/huffman_code_bit_packer.sv -----
// Path: a request passes the table read register, then a queue slot, then the
// output register; a full queue or out_ready low can stall it along the way.
// Throughput: one request per cycle unless stalled; the output drains one byte
// per cycle, so rate is bounded by the bytes each request produces (0 to 2).
// Reset: rst_n asynchronous, active low; clears pending bits, queue and output.
// The code table is not cleared by reset and holds undefined data until loaded.
module huffman_code_bit_packer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [hcbp_pkg::SYM_W-1:0]        symbol,
    input  logic [hcbp_pkg::MAX_CODE_LEN-1:0] code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]        code_length,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]       out_byte,
    output logic [hcbp_pkg::PAD_W-1:0]        pad_bits,
    output logic                              last
);

    logic               push_valid;
    logic               push_ready;
    hcbp_pkg::q_entry_t push_entry;
    logic               pop_valid;
    logic               pop_ready;
    hcbp_pkg::q_entry_t pop_entry;

    hcbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    hcbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    hcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .pad_bits  (pad_bits),
        .last      (last)
    );

endmodule

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_REQUESTS = 275;

    class byte_stream_model;
        logic [hcbp_pkg::MAX_CODE_LEN-1:0] code_of [hcbp_pkg::SYMBOL_COUNT];
        logic [hcbp_pkg::LEN_W-1:0]        len_of [hcbp_pkg::SYMBOL_COUNT];
        logic [hcbp_pkg::PEND_W-1:0]       held_bits;
        int                                held_count;
        hcbp_pkg::result_t                 expected_bytes[$];
        int                                errors;
        int                                bytes_checked;
        int                                flushes_checked;

        function new();
            held_bits = '0;
            held_count = 0;
            errors = 0;
            bytes_checked = 0;
            flushes_checked = 0;
        endfunction

        function void take_request(logic [1:0] op, logic [hcbp_pkg::SYM_W-1:0] sym,
                                   logic [hcbp_pkg::MAX_CODE_LEN-1:0] code,
                                   logic [hcbp_pkg::LEN_W-1:0] len);
            int                clen;
            int                acc;
            int                total;
            int                pad;
            hcbp_pkg::result_t r;
            case (op)
                hcbp_pkg::CMD_LOAD:
                begin
                    clen = (len > hcbp_pkg::MAX_CODE_LEN) ? hcbp_pkg::MAX_CODE_LEN : int'(len);
                    code_of[sym] = hcbp_pkg::MAX_CODE_LEN'(int'(code) & ((1 << clen) - 1));
                    len_of[sym] = hcbp_pkg::LEN_W'(clen);
                end
                hcbp_pkg::CMD_ENCODE:
                begin
                    clen = int'(len_of[sym]);
                    acc = (int'(held_bits) << clen) | int'(code_of[sym]);
                    total = held_count + clen;
                    while (total >= hcbp_pkg::BYTE_W)
                    begin
                        total -= hcbp_pkg::BYTE_W;
                        r.data = hcbp_pkg::BYTE_W'(acc >> total);
                        r.pad = '0;
                        r.last = 1'b0;
                        expected_bytes.push_back(r);
                    end
                    held_count = total;
                    held_bits = hcbp_pkg::PEND_W'(acc & ((1 << total) - 1));
                end
                hcbp_pkg::CMD_FLUSH:
                begin
                    if (held_count != 0)
                    begin
                        pad = hcbp_pkg::BYTE_W - held_count;
                        r.data = hcbp_pkg::BYTE_W'(int'(held_bits) << pad);
                        r.pad = hcbp_pkg::PAD_W'(pad);
                        r.last = 1'b1;
                        expected_bytes.push_back(r);
                        held_bits = '0;
                        held_count = 0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_byte(logic [hcbp_pkg::BYTE_W-1:0] data,
                                 logic [hcbp_pkg::PAD_W-1:0] pad, logic got_last);
            hcbp_pkg::result_t e;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected byte %02h (pad %0d, last %0b)", data, pad, got_last);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            bytes_checked++;
            if (e.last)
                flushes_checked++;
            if (data !== e.data)
            begin
                $error("out_byte: expected %02h, got %02h", e.data, data);
                errors++;
            end
            if (pad !== e.pad)
            begin
                $error("pad_bits: expected %0d, got %0d", e.pad, pad);
                errors++;
            end
            if (got_last !== e.last)
            begin
                $error("last: expected %0b, got %0b", e.last, got_last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [1:0]                        cmd = hcbp_pkg::CMD_LOAD;
    logic [hcbp_pkg::SYM_W-1:0]        symbol = '0;
    logic [hcbp_pkg::MAX_CODE_LEN-1:0] code_bits = '0;
    logic [hcbp_pkg::LEN_W-1:0]        code_length = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [hcbp_pkg::BYTE_W-1:0]       out_byte;
    logic [hcbp_pkg::PAD_W-1:0]        pad_bits;
    logic                              last;

    byte_stream_model            model = new();
    int                          cycles = 0;
    int                          sender_idle_pct = 0;
    int                          receiver_stall_pct = 0;
    int                          requests_sent = 0;
    bit                          loaded [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::SYM_W-1:0]  loaded_syms[$];

    huffman_code_bit_packer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .pad_bits    (pad_bits),
        .last        (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            model.check_byte(out_byte, pad_bits, last);
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send(input logic [1:0] op, input logic [hcbp_pkg::SYM_W-1:0] sym,
                        input logic [hcbp_pkg::MAX_CODE_LEN-1:0] code,
                        input logic [hcbp_pkg::LEN_W-1:0] len);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        symbol <= sym;
        code_bits <= code;
        code_length <= len;
        do
            @(posedge clk);
        while (!in_ready);
        model.take_request(op, sym, code, len);
        if (op != CMD_UNUSED)
            requests_sent++;
    endtask

    task automatic load_symbol(input logic [hcbp_pkg::SYM_W-1:0] sym,
                               input logic [hcbp_pkg::MAX_CODE_LEN-1:0] code,
                               input logic [hcbp_pkg::LEN_W-1:0] len);
        send(hcbp_pkg::CMD_LOAD, sym, code, len);
        if (!loaded[sym])
        begin
            loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    task automatic encode_known();
        send(hcbp_pkg::CMD_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
             hcbp_pkg::MAX_CODE_LEN'($urandom_range(16'hFFFF)),
             hcbp_pkg::LEN_W'($urandom_range(31)));
    endtask

    task automatic flush_tail();
        send(hcbp_pkg::CMD_FLUSH, hcbp_pkg::SYM_W'($urandom_range(255)),
             hcbp_pkg::MAX_CODE_LEN'($urandom_range(16'hFFFF)),
             hcbp_pkg::LEN_W'($urandom_range(31)));
    endtask

    function automatic logic [hcbp_pkg::LEN_W-1:0] random_length();
        if ($urandom_range(9) == 0)
            return hcbp_pkg::LEN_W'($urandom_range(31));
        return hcbp_pkg::LEN_W'($urandom_range(1, hcbp_pkg::MAX_CODE_LEN));
    endfunction

    task automatic random_phase(input int idle_pct, input int stall_pct);
        int target;
        int r;
        int n_load;
        int n_encode;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        target = requests_sent + PHASE_REQUESTS;
        while (requests_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 4)
                send(CMD_UNUSED, hcbp_pkg::SYM_W'($urandom_range(255)),
                     hcbp_pkg::MAX_CODE_LEN'($urandom_range(16'hFFFF)),
                     hcbp_pkg::LEN_W'($urandom_range(31)));
            else if (r < 8)
                flush_tail();
            else
            begin
                n_load = (loaded_syms.size() < 8) ? $urandom_range(2, 5) : $urandom_range(0, 2);
                repeat (n_load)
                    load_symbol(hcbp_pkg::SYM_W'($urandom_range(255)),
                                hcbp_pkg::MAX_CODE_LEN'($urandom_range(16'hFFFF)),
                                random_length());
                n_encode = $urandom_range(3, 16);
                repeat (n_encode)
                    encode_known();
                if ($urandom_range(99) < 60)
                    flush_tail();
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of codes and lengths, zero length, overlong length, stray bits
        load_symbol(8'h00, 16'hFFFF, 5'd16);
        load_symbol(8'hFF, 16'hFFFF, 5'd1);
        load_symbol(8'hAA, 16'hFFFF, 5'd0);
        load_symbol(8'h55, 16'hFFFF, 5'd31);
        load_symbol(8'h0F, 16'hFFFF, 5'd3);
        load_symbol(8'hF0, 16'h0000, 5'd8);
        flush_tail();
        send(hcbp_pkg::CMD_ENCODE, 8'h00, 16'h0000, 5'd0);
        flush_tail();
        send(hcbp_pkg::CMD_ENCODE, 8'hFF, 16'hFFFF, 5'd31);
        send(hcbp_pkg::CMD_ENCODE, 8'hAA, 16'h0000, 5'd0);
        send(hcbp_pkg::CMD_ENCODE, 8'h55, 16'h0000, 5'd0);
        flush_tail();
        send(hcbp_pkg::CMD_ENCODE, 8'h0F, 16'h0000, 5'd0);
        send(hcbp_pkg::CMD_ENCODE, 8'hF0, 16'h0000, 5'd0);
        flush_tail();
        send(CMD_UNUSED, 8'hFF, 16'hFFFF, 5'd31);
        load_symbol(8'h00, 16'h8001, 5'd17);
        send(hcbp_pkg::CMD_ENCODE, 8'hFF, 16'h0000, 5'd0);
        send(hcbp_pkg::CMD_ENCODE, 8'h00, 16'h0000, 5'd0);
        send(hcbp_pkg::CMD_ENCODE, 8'hAA, 16'h0000, 5'd0);
        flush_tail();

        random_phase(0, 0);
        random_phase(64, 0);
        random_phase(0, 64);
        random_phase(25, 25);

        in_valid <= 1'b0;
        while (model.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d requests sent, %0d symbols in use, %0d bytes checked",
                 requests_sent, loaded_syms.size(), model.bytes_checked);
        $display("%0d flushed tail bytes checked across four stall profiles",
                 model.flushes_checked);
        if (model.errors == 0 && model.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
